// File: design/tgl_pkg.sv
// tgl_pkg: shared types, codes and constants for the text glyph layout block.
// Holds the command format passed from the byte parser to the draw sequencer.
// No dependencies.
package tgl_pkg;

	localparam logic [3:0] MAX_CARET_ZEROS = 4'd8;
	localparam int         QUEUE_DEPTH     = 4;

	localparam logic [1:0] ACT_BEGIN = 2'd0;
	localparam logic [1:0] ACT_TEXT  = 2'd1;
	localparam logic [1:0] ACT_END   = 2'd2;

	localparam logic [1:0] KIND_GLYPH = 2'd0;
	localparam logic [1:0] KIND_COLOR = 2'd1;
	localparam logic [1:0] KIND_DONE  = 2'd2;

	localparam logic [7:0] CH_NUL     = 8'h00;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_CARET   = 8'h5E;
	localparam logic [7:0] CH_ASCII_END = 8'h80;
	localparam logic [7:0] CH_LEAD_LO = 8'hC1;
	localparam logic [7:0] CH_LEAD_HI = 8'hF5;
	localparam logic [3:0] DIGIT_HI_NIBBLE  = 4'h3;
	localparam logic [3:0] ACCENT_HI_NIBBLE = 4'h8;

	localparam logic [15:0] ACCENT_TABLE [12] = '{
		16'hC381, 16'hC389, 16'hC38D, 16'hC393, 16'hC39A, 16'hC391,
		16'hC3A1, 16'hC3A9, 16'hC3AD, 16'hC3B3, 16'hC3BA, 16'hC3B1
	};

	typedef enum logic [1:0] {
		PRE_NONE,
		PRE_ACCENT,
		PRE_COLOR,
		PRE_FLUSH
	} pre_op_t;

	typedef enum logic [2:0] {
		MAIN_NONE,
		MAIN_BEGIN,
		MAIN_SPACE,
		MAIN_NEWLINE,
		MAIN_GLYPH,
		MAIN_DONE
	} main_op_t;

	typedef enum logic [2:0] {
		STEP_MAIN,
		STEP_ACCENT,
		STEP_COLOR,
		STEP_CARET,
		STEP_ZEROS,
		STEP_DIGIT
	} step_t;

	typedef struct packed {
		pre_op_t     pre;
		logic [7:0]  pre_tile;
		logic [3:0]  zeros;
		logic [3:0]  digit;
		main_op_t    main;
		logic [7:0]  tile;
		logic [15:0] org_x;
		logic [15:0] org_y;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  tile;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic [2:0]  color;
		logic [15:0] count;
		logic        last;
	} result_t;

	typedef struct packed {
		logic       hit;
		logic [3:0] idx;
	} accent_t;

	function automatic accent_t accent_lookup(input logic [15:0] v);
		accent_t r;
		r = '0;
		for (int i = 0; i < 12; i++) begin
			if (ACCENT_TABLE[i] == v) begin
				r.hit = 1'b1;
				r.idx = 4'(i);
			end
		end
		return r;
	endfunction

endpackage

// File: design/tgl_front.sv
// tgl_front: byte parser. Tracks caret codes and UTF-8 sequences and turns each
// accepted item into at most one draw command for the sequencer.
// Depends on tgl_pkg.
module tgl_front import tgl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [7:0]  byte_value,
	input  logic [15:0] origin_x,
	input  logic [15:0] origin_y,
	input  logic        q_full,
	output logic        push,
	output cmd_t        cmd
);

	logic       caret_pending_q, caret_pending_d;
	logic [3:0] zero_run_q, zero_run_d;
	logic [3:0] digit_q, digit_d;
	logic       utf_pending_q, utf_pending_d;
	logic [7:0] lead_q, lead_d;
	logic [2:0] cont_seen_q, cont_seen_d;
	logic [7:0] cont_byte_q, cont_byte_d;

	logic       acc;
	logic       is_end;
	logic       is_digit;
	logic       do_plain;
	logic [3:0] d;
	accent_t    acc_r;
	cmd_t       c;

	assign in_ready = !q_full;
	assign acc      = in_valid && !q_full;
	assign is_end   = (action == ACT_END) || (action == ACT_TEXT && byte_value == CH_NUL);
	assign is_digit = (byte_value >= CH_ZERO) && (byte_value <= CH_NINE);
	assign d        = byte_value[3:0];
	assign acc_r    = accent_lookup({lead_q, cont_byte_q});

	always_comb begin
		c               = '0;
		c.pre           = PRE_NONE;
		c.main          = MAIN_NONE;
		do_plain        = 1'b0;
		caret_pending_d = caret_pending_q;
		zero_run_d      = zero_run_q;
		digit_d         = digit_q;
		utf_pending_d   = utf_pending_q;
		lead_d          = lead_q;
		cont_seen_d     = cont_seen_q;
		cont_byte_d     = cont_byte_q;

		if (action == ACT_BEGIN) begin
			c.main          = MAIN_BEGIN;
			c.org_x         = origin_x;
			c.org_y         = origin_y;
			caret_pending_d = 1'b0;
			zero_run_d      = '0;
			digit_d         = '0;
			utf_pending_d   = 1'b0;
			lead_d          = '0;
			cont_seen_d     = '0;
			cont_byte_d     = '0;
		end else if (is_end) begin
			if (utf_pending_q) begin
				if (cont_seen_q == 3'd1 && acc_r.hit) begin
					c.pre      = PRE_ACCENT;
					c.pre_tile = {ACCENT_HI_NIBBLE, acc_r.idx};
				end
			end else if (caret_pending_q) begin
				if (digit_q != '0) begin
					c.pre   = PRE_COLOR;
					c.digit = digit_q;
				end else begin
					c.pre   = PRE_FLUSH;
					c.zeros = zero_run_q;
				end
			end
			c.main          = MAIN_DONE;
			caret_pending_d = 1'b0;
			zero_run_d      = '0;
			digit_d         = '0;
			utf_pending_d   = 1'b0;
			lead_d          = '0;
			cont_seen_d     = '0;
			cont_byte_d     = '0;
		end else if (action == ACT_TEXT) begin
			if (utf_pending_q) begin
				if (byte_value[7:6] == 2'b10) begin
					if (cont_seen_q == '0)
						cont_byte_d = byte_value;
					if (cont_seen_q != 3'd7)
						cont_seen_d = cont_seen_q + 3'd1;
				end else begin
					if (cont_seen_q == 3'd1 && acc_r.hit) begin
						c.pre      = PRE_ACCENT;
						c.pre_tile = {ACCENT_HI_NIBBLE, acc_r.idx};
					end
					utf_pending_d = 1'b0;
					lead_d        = '0;
					cont_seen_d   = '0;
					cont_byte_d   = '0;
					do_plain      = 1'b1;
				end
			end else if (caret_pending_q) begin
				if (is_digit && digit_q == '0 && d == '0 && zero_run_q < MAX_CARET_ZEROS) begin
					zero_run_d = zero_run_q + 4'd1;
				end else if (is_digit && digit_q == '0 && d >= 4'd1 && d <= 4'd8) begin
					digit_d = d;
				end else begin
					if (!is_digit && digit_q != '0) begin
						c.pre   = PRE_COLOR;
						c.digit = digit_q;
					end else begin
						c.pre   = PRE_FLUSH;
						c.zeros = zero_run_q;
						c.digit = digit_q;
					end
					caret_pending_d = 1'b0;
					zero_run_d      = '0;
					digit_d         = '0;
					do_plain        = 1'b1;
				end
			end else begin
				do_plain = 1'b1;
			end
		end

		if (do_plain) begin
			if (byte_value == CH_SPACE) begin
				c.main = MAIN_SPACE;
			end else if (byte_value == CH_NEWLINE) begin
				c.main = MAIN_NEWLINE;
			end else if (byte_value == CH_CARET) begin
				caret_pending_d = 1'b1;
				zero_run_d      = '0;
				digit_d         = '0;
			end else if (byte_value < CH_ASCII_END) begin
				c.main = MAIN_GLYPH;
				c.tile = byte_value;
			end else if (byte_value > CH_LEAD_LO && byte_value < CH_LEAD_HI) begin
				utf_pending_d = 1'b1;
				lead_d        = byte_value;
				cont_seen_d   = '0;
				cont_byte_d   = '0;
			end
		end
	end

	assign cmd  = c;
	assign push = acc && (c.pre != PRE_NONE || c.main != MAIN_NONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			caret_pending_q <= 1'b0;
			zero_run_q      <= '0;
			digit_q         <= '0;
			utf_pending_q   <= 1'b0;
			lead_q          <= '0;
			cont_seen_q     <= '0;
			cont_byte_q     <= '0;
		end else if (acc) begin
			caret_pending_q <= caret_pending_d;
			zero_run_q      <= zero_run_d;
			digit_q         <= digit_d;
			utf_pending_q   <= utf_pending_d;
			lead_q          <= lead_d;
			cont_seen_q     <= cont_seen_d;
			cont_byte_q     <= cont_byte_d;
		end
	end

endmodule

// File: design/tgl_queue.sv
// tgl_queue: small command FIFO between the byte parser and the draw sequencer.
// Depth from tgl_pkg::QUEUE_DEPTH; head entry is read directly.
// Depends on tgl_pkg.
module tgl_queue import tgl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output cmd_t head,
	output logic not_empty,
	output logic full
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	cmd_t             entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign head      = entry_q[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign full      = (count_q == CNT_FULL);

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			if (push && !pop)
				count_q <= count_q + CNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - CNT_W'(1);
		end
	end

endmodule

// File: design/tgl_back.sv
// tgl_back: draw sequencer. Expands one command into glyph, colour and done
// results, keeps the cursor and the character count, and holds the result register.
// Depends on tgl_pkg.
module tgl_back import tgl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [6:0] glyph_step,
	input  logic       q_valid,
	input  cmd_t       q_cmd,
	output logic       q_pop,
	output logic       res_valid,
	output result_t    res,
	input  logic       res_ready
);

	logic        busy_q;
	step_t       step_q, step_d, step_first;
	logic [3:0]  zeros_q, zeros_d;
	logic [3:0]  digit_q;
	logic [7:0]  pre_tile_q;
	main_op_t    main_q;
	logic [7:0]  tile_q;
	logic [15:0] org_x_q, org_y_q;

	logic [15:0] cur_x_q, cur_y_q, line_x_q, count_q;
	logic        res_valid_q;
	result_t     res_q;

	logic        adv, finish, load;
	logic        main_silent;
	logic        emit, move_x, bump, set_org, new_line, clear_count;
	result_t     e;
	logic [15:0] step_ext;

	assign step_ext    = {9'b0, glyph_step};
	assign adv         = busy_q && (!res_valid_q || res_ready);
	assign finish      = adv && (step_q == STEP_MAIN);
	assign load        = q_valid && (!busy_q || finish);
	assign q_pop       = load;
	assign main_silent = (main_q == MAIN_NONE) || (main_q == MAIN_BEGIN) ||
	                     (main_q == MAIN_SPACE) || (main_q == MAIN_NEWLINE);

	always_comb begin
		unique case (q_cmd.pre)
			PRE_ACCENT: step_first = STEP_ACCENT;
			PRE_COLOR:  step_first = STEP_COLOR;
			PRE_FLUSH:  step_first = STEP_CARET;
			default:    step_first = STEP_MAIN;
		endcase
	end

	// next step
	always_comb begin
		step_d  = STEP_MAIN;
		zeros_d = zeros_q;
		unique case (step_q)
			STEP_CARET: begin
				if (zeros_q != '0)
					step_d = STEP_ZEROS;
				else if (digit_q != '0)
					step_d = STEP_DIGIT;
			end
			STEP_ZEROS: begin
				zeros_d = zeros_q - 4'd1;
				if (zeros_q != 4'd1)
					step_d = STEP_ZEROS;
				else if (digit_q != '0)
					step_d = STEP_DIGIT;
			end
			default: step_d = STEP_MAIN;
		endcase
	end

	// step outputs
	always_comb begin
		emit        = 1'b0;
		move_x      = 1'b0;
		bump        = 1'b0;
		set_org     = 1'b0;
		new_line    = 1'b0;
		clear_count = 1'b0;
		e           = '0;
		e.pos_x     = cur_x_q;
		e.pos_y     = cur_y_q;
		unique case (step_q)
			STEP_ACCENT: begin
				emit   = 1'b1;
				move_x = 1'b1;
				bump   = 1'b1;
				e.kind = KIND_GLYPH;
				e.tile = pre_tile_q;
				e.last = main_silent;
			end
			STEP_COLOR: begin
				emit    = 1'b1;
				e.kind  = KIND_COLOR;
				e.color = digit_q[2:0];
				e.last  = main_silent;
			end
			STEP_CARET, STEP_ZEROS, STEP_DIGIT: begin
				emit   = 1'b1;
				move_x = 1'b1;
				bump   = 1'b1;
				e.kind = KIND_GLYPH;
				if (step_q == STEP_CARET)
					e.tile = CH_CARET;
				else if (step_q == STEP_ZEROS)
					e.tile = CH_ZERO;
				else
					e.tile = {DIGIT_HI_NIBBLE, digit_q};
				e.last = (step_d == STEP_MAIN) && main_silent;
			end
			STEP_MAIN: begin
				case (main_q)
					MAIN_BEGIN: set_org = 1'b1;
					MAIN_SPACE: begin
						move_x = 1'b1;
						bump   = 1'b1;
					end
					MAIN_NEWLINE: begin
						new_line = 1'b1;
						bump     = 1'b1;
					end
					MAIN_GLYPH: begin
						emit   = 1'b1;
						move_x = 1'b1;
						bump   = 1'b1;
						e.kind = KIND_GLYPH;
						e.tile = tile_q;
						e.last = 1'b1;
					end
					MAIN_DONE: begin
						emit        = 1'b1;
						clear_count = 1'b1;
						e.kind      = KIND_DONE;
						e.count     = count_q;
						e.last      = 1'b1;
					end
					default: emit = 1'b0;
				endcase
			end
			default: emit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= STEP_MAIN;
		end else if (load) begin
			busy_q <= 1'b1;
			step_q <= step_first;
		end else if (finish) begin
			busy_q <= 1'b0;
		end else if (adv) begin
			step_q <= step_d;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			zeros_q    <= q_cmd.zeros;
			digit_q    <= q_cmd.digit;
			pre_tile_q <= q_cmd.pre_tile;
			main_q     <= q_cmd.main;
			tile_q     <= q_cmd.tile;
			org_x_q    <= q_cmd.org_x;
			org_y_q    <= q_cmd.org_y;
		end else if (adv) begin
			zeros_q <= zeros_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q  <= '0;
			cur_y_q  <= '0;
			line_x_q <= '0;
			count_q  <= '0;
		end else if (adv) begin
			if (set_org) begin
				cur_x_q  <= org_x_q;
				cur_y_q  <= org_y_q;
				line_x_q <= org_x_q;
				count_q  <= '0;
			end else begin
				if (move_x)
					cur_x_q <= cur_x_q + step_ext;
				if (new_line) begin
					cur_x_q <= line_x_q;
					cur_y_q <= cur_y_q + step_ext;
				end
				if (clear_count)
					count_q <= '0;
				else if (bump && count_q != 16'hFFFF)
					count_q <= count_q + 16'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (adv && emit)
			res_valid_q <= 1'b1;
		else if (res_ready)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv && emit)
			res_q <= e;
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// File: design/text_glyph_layout.sv
// text_glyph_layout: top level. Byte parser -> command queue -> draw sequencer,
// plus the glyph_step register.
// Depends on tgl_pkg, tgl_front, tgl_queue, tgl_back.
//
// channel    direction  signals                              contents
// s_axis     in         tvalid tready tdata[39:0] tuser[1:0] text item
// m_axis     out        tvalid tready tdata[63:0] tuser[1:0] tlast  draw event
// cfg        in         cfg_wen cfg_wdata[6:0]                glyph_step write
//
// The parser takes one item per cycle while the 4-entry command queue has room.
// The first result of an item passes the queue entry, the sequencer command registers and the result register.
// The sequencer takes one step per result, plus one step with no result for a space,
// newline or begin, or for a caret or UTF-8 prefix followed by nothing drawn.
// An m_axis stall holds the sequencer; the input stalls once the queue is full.
// Reset clears the cursor, count and parse state; glyph_step returns to 8.
module text_glyph_layout import tgl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,   // byte_value[7:0], origin_x[23:8], origin_y[39:24]
	input  logic [1:0]  s_axis_tuser,   // action[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // tile[7:0], pos_x[23:8], pos_y[39:24], red_on[40],
	                                    // green_on[41], blue_on[42], char_count[58:43], zero
	output logic [1:0]  m_axis_tuser,   // kind[1:0]
	output logic        m_axis_tlast,   // last
	input  logic        cfg_wen,
	input  logic [6:0]  cfg_wdata
);

	logic [6:0] glyph_step_q;
	logic       q_full, q_push, q_pop, q_not_empty;
	cmd_t       push_cmd, head_cmd;
	result_t    res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			glyph_step_q <= 7'd8;
		else if (cfg_wen)
			glyph_step_q <= cfg_wdata;
	end

	tgl_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.action     (s_axis_tuser),
		.byte_value (s_axis_tdata[7:0]),
		.origin_x   (s_axis_tdata[23:8]),
		.origin_y   (s_axis_tdata[39:24]),
		.q_full     (q_full),
		.push       (q_push),
		.cmd        (push_cmd)
	);

	tgl_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (push_cmd),
		.pop       (q_pop),
		.head      (head_cmd),
		.not_empty (q_not_empty),
		.full      (q_full)
	);

	tgl_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.glyph_step (glyph_step_q),
		.q_valid    (q_not_empty),
		.q_cmd      (head_cmd),
		.q_pop      (q_pop),
		.res_valid  (m_axis_tvalid),
		.res        (res),
		.res_ready  (m_axis_tready)
	);

	assign m_axis_tdata = {5'b0, res.count, res.color[2], res.color[1], res.color[0],
	                       res.pos_y, res.pos_x, res.tile};
	assign m_axis_tuser = res.kind;
	assign m_axis_tlast = res.last;

endmodule
